/* rtl/core/esmf_pkg.sv */
// Shared sizes, register indexes and types for the exact substring match finder.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package esmf_pkg;

  localparam int MAX_NEEDLE_BYTES = 16;
  localparam int POSITION_BITS    = 32;

  localparam int BYTE_BITS   = 8;
  localparam int LEN_BITS    = 5;
  localparam int WORD_BITS   = 64;
  localparam int START_BITS  = 32;
  localparam int INDEX_BITS  = 2;
  localparam int SEL_BITS    = (MAX_NEEDLE_BYTES > 1) ? $clog2(MAX_NEEDLE_BYTES) : 1;
  localparam int IN_DATA_BITS  = 8;
  localparam int OUT_DATA_BITS = 40;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_NEEDLE_LENGTH = 2'd0,
    REG_NEEDLE_LOW    = 2'd1,
    REG_NEEDLE_HIGH   = 2'd2
  } reg_index_t;

  typedef logic [POSITION_BITS-1:0] position_t;

  // Position of the current byte and the saturation flag after its update.
  typedef struct packed {
    position_t pos;
    logic      overflow;
  } pos_status_t;

endpackage

/* rtl/core/esmf_cell.sv */
// One cell of the text window chain: holds one byte of recent text, hands it on to its
// right neighbour and compares the byte it receives with its needle byte. Uses esmf_pkg.
module esmf_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           clear,
  input  logic [esmf_pkg::BYTE_BITS-1:0] byte_in,
  input  logic [esmf_pkg::BYTE_BITS-1:0] needle_byte,
  output logic [esmf_pkg::BYTE_BITS-1:0] byte_out,
  output logic                           same
);

  logic [esmf_pkg::BYTE_BITS-1:0] byte_r;
  logic [esmf_pkg::BYTE_BITS-1:0] byte_nxt;

  // The byte arriving from the left is this cell's window byte for the current item.
  assign same     = (byte_in == needle_byte);
  assign byte_out = byte_r;

  always_comb begin
    byte_nxt = byte_r;
    if (step) begin
      byte_nxt = clear ? '0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

endmodule

/* rtl/core/esmf_position.sv */
// Saturating byte position counter for the current text, with its overflow flag.
// Uses esmf_pkg.
module esmf_position (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 clear,
  output esmf_pkg::pos_status_t status
);

  localparam esmf_pkg::position_t POS_MAX = '1;

  esmf_pkg::position_t bytes_seen_r, bytes_seen_nxt;
  logic                sat_r, sat_nxt;
  logic                at_max;

  assign at_max          = (bytes_seen_r == POS_MAX);
  assign status.pos      = bytes_seen_r;
  assign status.overflow = sat_r || at_max;

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    sat_nxt        = sat_r;
    if (step) begin
      if (clear) begin
        bytes_seen_nxt = '0;
        sat_nxt        = 1'b0;
      end else if (at_max) begin
        sat_nxt = 1'b1;
      end else begin
        bytes_seen_nxt = bytes_seen_r + esmf_pkg::position_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      sat_r        <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      sat_r        <= sat_nxt;
    end
  end

endmodule

/* rtl/core/exact_substring_match_finder_core.sv */
// Top level of the exact substring match finder: configuration registers, the cell
// chain, the position counter and the output register. Uses esmf_pkg, esmf_cell, esmf_position.
//
// The block takes one text byte per clock and returns one result item per byte, in the
// cycle after it is accepted; a new byte is taken in every cycle as long as the output
// register is empty or being emptied. The text window is held by a row of 15 cells that
// shift the recent bytes along by one place per accepted byte; together with the current
// byte they give the last 16 bytes, and each is compared in parallel with the needle byte
// that lines up with it for the configured length, so the needle registers may change
// between any two items. A result flags a match whose last byte is the current one,
// including overlapping matches, and gives its zero-based start. The item with tlast set
// ends the text and restarts the window and the position counter. Write the needle
// registers only while no item is in flight.
module exact_substring_match_finder_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [esmf_pkg::INDEX_BITS-1:0]      cfg_index,
  input  logic [esmf_pkg::WORD_BITS-1:0]       cfg_data,
  // Text input.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [esmf_pkg::IN_DATA_BITS-1:0]    in_tdata,   // [7:0] text_byte
  input  logic                                 in_tlast,   // is_last
  // Results.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] match_found, [32:1] match_start, [33] position_overflow, [39:34] zero
  output logic [esmf_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  output logic                                 out_tlast   // end_of_text
);

  localparam int MAXN = esmf_pkg::MAX_NEEDLE_BYTES;
  localparam int BB   = esmf_pkg::BYTE_BITS;

  logic [esmf_pkg::LEN_BITS-1:0]  needle_length_r;
  logic [esmf_pkg::WORD_BITS-1:0] needle_low_r;
  logic [esmf_pkg::WORD_BITS-1:0] needle_high_r;
  logic [2*esmf_pkg::WORD_BITS-1:0] needle_all;

  logic                           step;
  logic [MAXN-1:0][BB-1:0]        window;
  logic [MAXN-1:0][BB-1:0]        needle_sel;
  logic [MAXN-1:0]                same;
  logic [MAXN-1:0]                in_use;
  esmf_pkg::pos_status_t          pos_status;

  logic [esmf_pkg::LEN_BITS-1:0]  len_eff;
  logic [esmf_pkg::SEL_BITS-1:0]  sel;
  logic                           count_ok;
  logic                           found;
  esmf_pkg::position_t            start;

  logic                           out_valid_r;
  logic                           found_r;
  logic [esmf_pkg::START_BITS-1:0] start_r;
  logic                           overflow_r;
  logic                           last_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_length_r <= '0;
      needle_low_r    <= '0;
      needle_high_r   <= '0;
    end else if (cfg_valid) begin
      case (esmf_pkg::reg_index_t'(cfg_index))
        esmf_pkg::REG_NEEDLE_LENGTH: needle_length_r <= cfg_data[esmf_pkg::LEN_BITS-1:0];
        esmf_pkg::REG_NEEDLE_LOW:    needle_low_r    <= cfg_data;
        esmf_pkg::REG_NEEDLE_HIGH:   needle_high_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign needle_all = {needle_high_r, needle_low_r};

  // Lengths beyond the cell count use the whole window.
  assign len_eff = (needle_length_r > esmf_pkg::LEN_BITS'(MAXN)) ?
                   esmf_pkg::LEN_BITS'(MAXN) : needle_length_r;
  assign sel     = esmf_pkg::SEL_BITS'(len_eff - esmf_pkg::LEN_BITS'(1));

  // Window byte b lies b places back from the current byte and meets needle byte
  // len - 1 - b; bytes beyond the needle length take no part.
  always_comb begin
    for (int b = 0; b < MAXN; b++) begin
      needle_sel[b] = '0;
      in_use[b]     = (int'(len_eff) > b);
      for (int k = 0; k < MAXN; k++) begin
        if (int'(len_eff) == b + k + 1) begin
          needle_sel[b] = needle_all[BB*k +: BB];
        end
      end
    end
  end

  // ---------------- cell chain ----------------
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;
  assign window[0] = in_tdata[BB-1:0];

  for (genvar j = 0; j < MAXN - 1; j++) begin : g_cell
    esmf_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .step        (step),
      .clear       (in_tlast),
      .byte_in     (window[j]),
      .needle_byte (needle_sel[j]),
      .byte_out    (window[j+1]),
      .same        (same[j])
    );
  end

  // The oldest window byte is not handed on, so it is compared here.
  assign same[MAXN-1] = (window[MAXN-1] == needle_sel[MAXN-1]);

  esmf_position u_position (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .clear  (in_tlast),
    .status (pos_status)
  );

  // Once the counter has saturated, the byte-count condition always holds.
  assign count_ok = pos_status.overflow || (pos_status.pos >= esmf_pkg::position_t'(sel));
  assign found    = (len_eff != '0) && count_ok && (&(same | ~in_use));
  assign start    = pos_status.pos - esmf_pkg::position_t'(sel);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      found_r    <= found;
      start_r    <= found ? esmf_pkg::START_BITS'(start) : '0;
      overflow_r <= pos_status.overflow;
      last_r     <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'b0, overflow_r, start_r, found_r};

endmodule
